>>> design/thrmbeta_pkg.sv
// ---------------------------------------------------------------------------
// Thermistor Beta temperature package
// Shared constants, fault codes and register indexes.
// ---------------------------------------------------------------------------
package thrmbeta_pkg;

	localparam int ADC_BITS_DEF = 10;

	// Configuration register widths and reset values.
	localparam int OHM_W   = 20;
	localparam int T0C_W   = 10;
	localparam int BETA_W  = 14;
	localparam int CFG_W   = 20;
	localparam int CIDX_W  = 8;

	localparam logic [OHM_W-1:0]  DIV_OHMS_RST = 20'd4700;
	localparam logic [OHM_W-1:0]  NOM_OHMS_RST = 20'd100000;
	localparam logic [T0C_W-1:0]  NOM_T0C_RST  = 10'd25;
	localparam logic [BETA_W-1:0] BETA_RST     = 14'd4267;

	// Logarithm lanes and formats.
	localparam int LANES     = 4;
	localparam int LOG_STEPS = 24;
	localparam int MANT_W    = 31;
	localparam int EXP_W     = 5;
	localparam int LOG_W     = EXP_W + LOG_STEPS;

	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	// Output and quotient.
	localparam int TEMP_W = 17;
	localparam int QUO_W  = 18;
	localparam logic [QUO_W-1:0] QUO_LIMIT = 18'd92850;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 17'sd65535;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -17'sd27315;
	localparam logic [QUO_W-1:0] CK_OFFSET = 18'd27315;

	typedef enum logic [1:0] {
		FLT_OK    = 2'd0,
		FLT_SHORT = 2'd1,
		FLT_OPEN  = 2'd2
	} fault_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_DIV_OHMS = 8'd0,
		REG_NOM_OHMS = 8'd1,
		REG_NOM_T0C  = 8'd2,
		REG_BETA     = 8'd3
	} reg_idx_t;

endpackage

>>> design/thermistor_beta_temperature.sv
// ---------------------------------------------------------------------------
// Thermistor Beta temperature
// Converts a divider ADC code to hundredths of a degree Celsius.
// ---------------------------------------------------------------------------
// Usage:
// One ADC code enters per transfer on the s_axis channel; one result leaves
// per transfer on the m_axis channel, temperature in tdata and the fault
// code in tuser (0 ok, 1 shorted, 2 open). Registers are written over the
// cfg channel, which is always ready; write them only while the block is
// empty. The pipeline has 49 stages plus the output register. A new code
// is taken in every cycle while the output is not stalled. The stages are
// the input stage, the 24 squaring stages of the four logarithm lanes, six
// stages of log and product arithmetic and the 18 quotient stages of the
// divider, followed by the output register.
// The whole pipeline advances together: when the receiver holds tready low
// while a result is waiting, s_axis tready falls and every stage holds.
// Reset clears all valid bits and loads the register defaults
// (4700 ohm divider, 100 kohm at 25 C, Beta 4267).
// ---------------------------------------------------------------------------
module thermistor_beta_temperature
	import thrmbeta_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_axis_tdata: adc_code [ADC_BITS-1:0]
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [((ADC_BITS+7)/8)*8-1:0]     s_axis_tdata,
	// m_axis_tdata: temp_centi_c [16:0], zero fill above
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [23:0]                       m_axis_tdata,
	// m_axis_tuser: fault [1:0]
	output logic [1:0]                        m_axis_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [CIDX_W-1:0]                 cfg_index,
	input  logic [CFG_W-1:0]                  cfg_data
);

	localparam int NS   = 1 + LOG_STEPS + 6 + QUO_W;
	localparam int LAST = NS - 1;

	// Configuration registers.
	logic [OHM_W-1:0]  div_ohms_q;
	logic [OHM_W-1:0]  nom_ohms_q;
	logic [T0C_W-1:0]  nom_t0c_q;
	logic [BETA_W-1:0] beta_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_ohms_q <= DIV_OHMS_RST;
			nom_ohms_q <= NOM_OHMS_RST;
			nom_t0c_q  <= NOM_T0C_RST;
			beta_q     <= BETA_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_DIV_OHMS) div_ohms_q <= cfg_data;
			if (cfg_index == REG_NOM_OHMS) nom_ohms_q <= cfg_data;
			if (cfg_index == REG_NOM_T0C)  nom_t0c_q  <= cfg_data[T0C_W-1:0];
			if (cfg_index == REG_BETA)     beta_q     <= cfg_data[BETA_W-1:0];
		end
	end

	logic en;
	logic out_v_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [1:0] fault_q;

	assign en            = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;

	// Valid bit and fault code travel with every stage.
	logic       tg_v_s [NS];
	logic [1:0] tg_f_s [NS];

	// Input decode.
	logic [ADC_BITS-1:0] code;
	logic [ADC_BITS-1:0] fs_code;
	logic [1:0]          in_fault;
	logic [OHM_W-1:0]    lane_x  [LANES];
	logic [EXP_W-1:0]    norm_n  [LANES];
	logic [MANT_W-1:0]   norm_m  [LANES];

	assign code    = s_axis_tdata[ADC_BITS-1:0];
	assign fs_code = {ADC_BITS{1'b1}} - code;

	always_comb begin
		if (code == '0) begin
			in_fault = FLT_SHORT;
		end else if (code == {ADC_BITS{1'b1}}) begin
			in_fault = FLT_OPEN;
		end else begin
			in_fault = FLT_OK;
		end
		lane_x[0] = div_ohms_q;
		lane_x[1] = OHM_W'(code);
		lane_x[2] = OHM_W'(fs_code);
		lane_x[3] = nom_ohms_q;
		for (int l = 0; l < LANES; l++) begin
			// Zero reads as one, which also covers fault codes.
			if (lane_x[l] == '0) lane_x[l] = OHM_W'(1);
			norm_n[l] = '0;
			for (int i = 0; i < OHM_W; i++) begin
				if (lane_x[l][i]) norm_n[l] = EXP_W'(i);
			end
			norm_m[l] = MANT_W'({{(MANT_W-OHM_W){1'b0}}, lane_x[l]} << (EXP_W'(30) - norm_n[l]));
		end
	end

	// Logarithm lanes: one squaring and one fraction bit per stage.
	logic [MANT_W-1:0]    lg_m_s [LANES][LOG_STEPS+1];
	logic [EXP_W-1:0]     lg_n_s [LANES][LOG_STEPS+1];
	logic [LOG_STEPS-1:0] lg_f_s [LANES][LOG_STEPS+1];
	logic [MANT_W-1:0]    sq_m   [LANES][LOG_STEPS];
	logic                 sq_b   [LANES][LOG_STEPS];

	always_comb begin
		logic [2*MANT_W-1:0] sq;
		logic [31:0]         t;
		for (int l = 0; l < LANES; l++) begin
			for (int k = 0; k < LOG_STEPS; k++) begin
				sq = lg_m_s[l][k] * lg_m_s[l][k];
				t  = sq[61:30];
				sq_b[l][k] = t[31];
				sq_m[l][k] = t[31] ? t[31:1] : t[30:0];
			end
		end
	end

	// Later arithmetic stages.
	logic signed [30:0] l2_s25;
	logic               neg_s26;
	logic [59:0]        prod_s26;
	logic signed [30:0] ln_s27;
	logic [20:0]        hb_s28;
	logic signed [39:0] nump_s28;
	logic signed [48:0] tl_s28;

	logic [63:0] dv_r_s   [QUO_W+1];
	logic [49:0] dv_ad_s  [QUO_W+1];
	logic [QUO_W-1:0] dv_q_s [QUO_W+1];
	logic        dv_neg_s [QUO_W+1];
	logic        dv_dz_s  [QUO_W+1];
	logic        dv_ovf_s [QUO_W+1];

	logic [63:0] an_s29;
	logic [49:0] ad_s29;
	logic        neg_s29;
	logic        dz_s29;

	logic [LOG_W-1:0]   lg_full [LANES];
	logic signed [30:0] l2_sum;
	logic [29:0]        l2_mag;
	logic [59:0]        ln_rnd;
	logic [29:0]        ln_mag;
	logic [20:0]        hb;
	logic signed [17:0] t0ck;
	logic signed [63:0] num;
	logic signed [49:0] den;
	logic [63:0]        dvd;
	logic               ovf;
	logic [63:0]        dv_r_nx [QUO_W];
	logic               dv_ge   [QUO_W];

	always_comb begin
		logic [68:0] trial;
		for (int l = 0; l < LANES; l++) begin
			lg_full[l] = {lg_n_s[l][LOG_STEPS], lg_f_s[l][LOG_STEPS]};
		end
		l2_sum = $signed({2'b0, lg_full[0]}) + $signed({2'b0, lg_full[1]})
			- $signed({2'b0, lg_full[2]}) - $signed({2'b0, lg_full[3]});
		l2_mag = l2_s25[30] ? 30'(-l2_s25) : 30'(l2_s25);
		ln_rnd = prod_s26 + 60'(1) * 60'h20000000;
		ln_mag = ln_rnd[59:30];
		hb     = 21'(beta_q * 21'd100);
		t0ck   = 18'($signed(nom_t0c_q) * 18'sd100 + 18'sd27315);
		num    = {nump_s28, 24'b0};
		den    = $signed({5'b0, hb_s28, 24'b0}) + 50'(tl_s28);
		dvd    = an_s29 + {15'b0, ad_s29[49:1]};
		ovf    = {4'b0, dvd} >= {ad_s29, 18'b0};
		for (int j = 0; j < QUO_W; j++) begin
			trial = {5'b0, dv_r_s[j]} - ({19'b0, dv_ad_s[j]} << (QUO_W - 1 - j));
			dv_ge[j]   = !trial[68];
			dv_r_nx[j] = dv_ge[j] ? trial[63:0] : dv_r_s[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				lg_m_s[l][0] <= norm_m[l];
				lg_n_s[l][0] <= norm_n[l];
				lg_f_s[l][0] <= '0;
				for (int k = 1; k <= LOG_STEPS; k++) begin
					lg_m_s[l][k] <= sq_m[l][k-1];
					lg_n_s[l][k] <= lg_n_s[l][k-1];
					lg_f_s[l][k] <= {lg_f_s[l][k-1][LOG_STEPS-2:0], sq_b[l][k-1]};
				end
			end
			l2_s25   <= l2_sum;
			neg_s26  <= l2_s25[30];
			prod_s26 <= l2_mag * LN2_Q30;
			ln_s27   <= neg_s26 ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});
			hb_s28   <= hb;
			nump_s28 <= $signed({1'b0, hb}) * t0ck;
			tl_s28   <= t0ck * ln_s27;
			an_s29   <= num[63] ? 64'(-num) : 64'(num);
			ad_s29   <= den[49] ? 50'(-den) : 50'(den);
			neg_s29  <= num[63] ^ den[49];
			dz_s29   <= den == '0;
			dv_r_s[0]   <= dvd;
			dv_ad_s[0]  <= ad_s29;
			dv_q_s[0]   <= '0;
			dv_neg_s[0] <= neg_s29;
			dv_dz_s[0]  <= dz_s29;
			dv_ovf_s[0] <= ovf;
			for (int j = 1; j <= QUO_W; j++) begin
				dv_r_s[j]   <= dv_r_nx[j-1];
				dv_ad_s[j]  <= dv_ad_s[j-1];
				dv_q_s[j]   <= {dv_q_s[j-1][QUO_W-2:0], dv_ge[j-1]};
				dv_neg_s[j] <= dv_neg_s[j-1];
				dv_dz_s[j]  <= dv_dz_s[j-1];
				dv_ovf_s[j] <= dv_ovf_s[j-1];
			end
		end
	end

	// Final selection and saturation.
	logic signed [TEMP_W-1:0] temp_nx;
	logic [QUO_W-1:0]         quo;

	assign quo = dv_q_s[QUO_W];

	always_comb begin
		priority if (tg_f_s[LAST] == FLT_SHORT) begin
			temp_nx = TEMP_MAX;
		end else if (tg_f_s[LAST] == FLT_OPEN) begin
			temp_nx = TEMP_MIN;
		end else if (dv_dz_s[QUO_W]) begin
			temp_nx = TEMP_MAX;
		end else if (dv_neg_s[QUO_W]) begin
			temp_nx = TEMP_MIN;
		end else if (dv_ovf_s[QUO_W] || quo > QUO_LIMIT) begin
			temp_nx = TEMP_MAX;
		end else begin
			temp_nx = TEMP_W'($signed({1'b0, quo}) - $signed({1'b0, CK_OFFSET}));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tg_f_s[0] <= in_fault;
			for (int k = 1; k < NS; k++) begin
				tg_f_s[k] <= tg_f_s[k-1];
			end
			temp_q  <= temp_nx;
			fault_q <= tg_f_s[LAST];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				tg_v_s[k] <= 1'b0;
			end
			out_v_q <= 1'b0;
		end else if (en) begin
			tg_v_s[0] <= s_axis_tvalid;
			for (int k = 1; k < NS; k++) begin
				tg_v_s[k] <= tg_v_s[k-1];
			end
			out_v_q <= tg_v_s[LAST];
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'b0, temp_q};
	assign m_axis_tuser  = fault_q;

	a_no_bad_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("fault code out of range");

	a_short_hot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == FLT_SHORT) |-> temp_q == TEMP_MAX)
		else $error("shorted result not at hottest value");

	a_open_cold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == FLT_OPEN) |-> temp_q == TEMP_MIN)
		else $error("open result not at coldest value");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (temp_q >= TEMP_MIN && temp_q <= TEMP_MAX))
		else $error("temperature outside saturation range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_axis_tready) |=> $stable(tg_v_s[LAST]))
		else $error("pipeline moved during output stall");

endmodule
